FILE: rtl/core/ssr_pkg.sv
// Shared types and constants for the stepper speed ramp.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ssr_pkg;

   localparam int SPEED_W    = 16;
   localparam int RATE_W     = 20;
   localparam int REQ_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = RATE_W;

   localparam logic [SPEED_W-1:0] SET_SPEED_FLOOR = 16'd200;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 16'd10000;
   localparam logic [RATE_W-1:0]  RATE_RST        = 20'd20000;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK      = 3'd0,
      REQ_ACCEL     = 3'd1,
      REQ_DECEL     = 3'd2,
      REQ_STOP      = 3'd3,
      REQ_SET_SPEED = 3'd4
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_SPEED  = 2'd0,
      CSR_ACCEL_RATE = 2'd1,
      CSR_DECEL_RATE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV
   } ssr_state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: rtl/core/ssr_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on ssr_pkg.
`timescale 1ns / 1ps

interface ssr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ssr_pkg::REQ_W-1:0]    req_type;
   logic [ssr_pkg::SPEED_W-1:0]  speed_value;

   modport source (output valid, output req_type, output speed_value, input ready);
   modport sink   (input valid, input req_type, input speed_value, output ready);
endinterface

interface ssr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ssr_pkg::SPEED_W-1:0]  speed;
   logic                         ramp_done;
   logic                         ramp_running;

   modport source (output valid, output speed, output ramp_done, output ramp_running,
                   input ready);
   modport sink   (input valid, input speed, input ramp_done, input ramp_running,
                   output ready);
endinterface

FILE: rtl/core/ssr_div.sv
// Iterative restoring divider: CLOCK_HZ / divisor, one quotient bit per cycle.
// Depends on ssr_pkg. Divisor zero yields an all-ones quotient.
`timescale 1ns / 1ps

module ssr_div #(
   parameter int CLOCK_HZ = 72000000
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ssr_pkg::RATE_W-1:0]   divisor,
   output ssr_pkg::div_stat_type        stat,
   output logic [ssr_pkg::SPEED_W-1:0]  quotient
);
   import ssr_pkg::*;

   localparam int DW  = $clog2(CLOCK_HZ + 1);
   localparam int CW  = $clog2(DW + 1);
   localparam logic [DW-1:0] DIVIDEND = DW'(CLOCK_HZ);
   localparam logic [CW-1:0] STEPS    = CW'(DW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              zero_ff, zero_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         zero_in = (divisor == '0);
         cnt_in  = STEPS;
         rem_in  = '0;
         quo_in  = DIVIDEND;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shared subtract/compare: one restoring step
         if (!diff[RATE_W]) begin
            rem_in = diff[RATE_W-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[RATE_W-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign stat     = '{busy: busy_ff, done: done_ff};
   // zero divisor saturates
   assign quotient = zero_ff ? '1 : quo_ff[SPEED_W-1:0];

endmodule

FILE: rtl/core/stepper_speed_ramp.sv
// Stepper speed ramp top level: sequencer, ramp state, config regs, response register.
// Depends on ssr_pkg, ssr_if (ssr_req_if, ssr_rsp_if) and ssr_div.
//
//   channel   dir   handshake       payload
//   req_if    in    valid/ready     req_type[2:0], speed_value[15:0]
//   rsp_if    out   valid/ready     speed[15:0], ramp_done, ramp_running
//   csr_*     in    write enable    csr_index[1:0], csr_wdata[19:0]
//
// Tick, stop, set speed and unknown codes are answered straight from the idle state; a
// ramp start waits in the divide state for the one-bit-per-cycle prescale divider.
// Synchronous active-high reset, no clearing pass. req_if.ready drops while a start
// divides and while an unread response sits in the output register.
`timescale 1ns / 1ps

module stepper_speed_ramp #(
   parameter int CLOCK_HZ  = 72000000,
   parameter int MIN_SPEED = 200
) (
   input  logic                            clock,
   input  logic                            reset,
   ssr_req_if.sink                         req_if,
   ssr_rsp_if.source                       rsp_if,
   input  logic                            csr_write_en,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssr_pkg::*;

   localparam logic [SPEED_W-1:0] MIN_SPEED_V = SPEED_W'(MIN_SPEED);

   // config registers
   logic [SPEED_W-1:0] max_speed_ff;
   logic [RATE_W-1:0]  accel_rate_ff;
   logic [RATE_W-1:0]  decel_rate_ff;

   // ramp state
   logic               decel_mode_ff, decel_mode_in;
   logic               running_ff, running_in;
   logic               done_ff, done_in;
   logic [SPEED_W-1:0] ramp_count_ff, ramp_count_in;
   logic [SPEED_W-1:0] ramp_top_ff, ramp_top_in;
   logic [SPEED_W-1:0] prescale_value_ff, prescale_value_in;
   logic [SPEED_W-1:0] prescale_count_ff, prescale_count_in;

   // sequencer
   ssr_state_type      state_ff, state_in;
   logic               pend_decel_ff, pend_decel_in;   // ramp kind held over the divide

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic               rsp_done_ff;
   logic               rsp_running_ff;

   logic               accept;
   logic               is_start;
   logic               div_start;
   logic               load_rsp;
   logic [RATE_W-1:0]  div_divisor;
   div_stat_type       div_stat;
   logic [SPEED_W-1:0] div_quotient;
   logic [SPEED_W-1:0] spd_sel;

   // ---------------------------------------------------------------- handshake
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign is_start     = (req_if.req_type == REQ_ACCEL) || (req_if.req_type == REQ_DECEL);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- sequencer outputs
   always_comb begin
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            div_start = accept && is_start;
            load_rsp  = accept && !is_start;
         end
         ST_DIV: begin
            load_rsp = div_stat.done;
         end
         default: ;
      endcase
   end

   assign div_divisor = (req_if.req_type == REQ_DECEL) ? decel_rate_ff : accel_rate_ff;

   ssr_div #(
      .CLOCK_HZ (CLOCK_HZ)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------- ramp update
   always_comb begin
      decel_mode_in     = decel_mode_ff;
      running_in        = running_ff;
      done_in           = done_ff;
      ramp_count_in     = ramp_count_ff;
      ramp_top_in       = ramp_top_ff;
      prescale_value_in = prescale_value_ff;
      prescale_count_in = prescale_count_ff;
      pend_decel_in     = pend_decel_ff;

      if (state_ff == ST_DIV) begin
         // ramp start lands once the prescale quotient is ready
         if (div_stat.done) begin
            decel_mode_in     = pend_decel_ff;
            done_in           = 1'b0;
            running_in        = 1'b1;
            prescale_value_in = div_quotient;
            prescale_count_in = '0;
            if (pend_decel_ff) begin
               ramp_top_in   = max_speed_ff - MIN_SPEED_V;
               ramp_count_in = max_speed_ff - ramp_count_ff;
            end else begin
               ramp_top_in   = max_speed_ff;
               ramp_count_in = MIN_SPEED_V;
            end
         end
      end else if (accept) begin
         unique case (req_if.req_type)
            REQ_TICK: begin
               if (running_ff) begin
                  if (prescale_count_ff >= prescale_value_ff) begin
                     prescale_count_in = '0;
                     // count at or past top ends the ramp, no wrap
                     if (ramp_count_ff >= ramp_top_ff) begin
                        done_in       = 1'b1;
                        ramp_count_in = ramp_top_ff;
                        running_in    = 1'b0;
                     end else begin
                        ramp_count_in = ramp_count_ff + 1'b1;
                     end
                  end else begin
                     prescale_count_in = prescale_count_ff + 1'b1;
                  end
               end
            end
            REQ_ACCEL:     pend_decel_in = 1'b0;
            REQ_DECEL:     pend_decel_in = 1'b1;
            REQ_STOP:      running_in    = 1'b0;
            REQ_SET_SPEED: begin
               ramp_count_in = (req_if.speed_value < SET_SPEED_FLOOR) ?
                               SET_SPEED_FLOOR : req_if.speed_value;
            end
            default: ;   // unknown codes only report status
         endcase
      end
   end

   // reported speed: held top once done, complemented against max speed in decel
   assign spd_sel      = done_in ? ramp_top_in : ramp_count_in;
   assign rsp_speed_in = decel_mode_in ? (max_speed_ff - spd_sel) : spd_sel;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)          rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff      <= MAX_SPEED_RST;
         accel_rate_ff     <= RATE_RST;
         decel_rate_ff     <= RATE_RST;
         decel_mode_ff     <= 1'b0;
         running_ff        <= 1'b0;
         done_ff           <= 1'b0;
         ramp_count_ff     <= '0;
         ramp_top_ff       <= '1;
         prescale_value_ff <= '1;
         prescale_count_ff <= '0;
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[SPEED_W-1:0];
               CSR_ACCEL_RATE: accel_rate_ff <= csr_wdata;
               CSR_DECEL_RATE: decel_rate_ff <= csr_wdata;
               default: ;
            endcase
         end
         decel_mode_ff     <= decel_mode_in;
         running_ff        <= running_in;
         done_ff           <= done_in;
         ramp_count_ff     <= ramp_count_in;
         ramp_top_ff       <= ramp_top_in;
         prescale_value_ff <= prescale_value_in;
         prescale_count_ff <= prescale_count_in;
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      pend_decel_ff <= pend_decel_in;
      if (load_rsp) begin
         rsp_speed_ff   <= rsp_speed_in;
         rsp_done_ff    <= done_in;
         rsp_running_ff <= running_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.speed        = rsp_speed_ff;
   assign rsp_if.ramp_done    = rsp_done_ff;
   assign rsp_if.ramp_running = rsp_running_ff;

   // ---------------------------------------------------------------- assertions
`ifndef ASSERT_OFF
   a_done_excl_run: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && running_ff))
      else $error("ramp done and running both set");

   a_presc_bound: assert property (@(posedge clock) disable iff (reset)
      prescale_count_ff <= prescale_value_ff)
      else $error("prescale count passed prescale value");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && is_start) |=> (!rsp_valid_ff && div_stat.busy))
      else $error("start transaction did not launch divider cleanly");
`endif

endmodule
